### rtl/cuckoo_hash_insert_three_way_top_assert.svh
// Assertion macros for the three-way cuckoo insert block.
// Included by the modules that carry concurrent checks.
`ifndef CUCKOO_HASH_INSERT_THREE_WAY_TOP_ASSERT_SVH
`define CUCKOO_HASH_INSERT_THREE_WAY_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CHI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CHI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/chi_pkg.sv
// Package for the three-way cuckoo insert block: payload types, commands, sizes.
// No dependencies.
package chi_pkg;
  localparam int MAX_ITEMS   = 1024;
  localparam int TABLE_SLOTS = 2048;
  localparam int ITEM_W      = $clog2(MAX_ITEMS);
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int SLICE_AW    = $clog2(3 * MAX_ITEMS);
  localparam int MOD_W       = 12;
  localparam int KICK_W      = 10;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic CFG_MAX_KICKS  = 1'b1;

  localparam logic [MOD_W-1:0]  TABLE_SIZE_RST = 12'd1331;
  localparam logic [KICK_W-1:0] MAX_KICKS_RST  = 10'd500;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  item_number;
    logic [1:0]  slice_sel;
    logic [63:0] slice_data;
    logic [10:0] slot_number;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] slot_key;
    logic [10:0] slot_value;
    logic [1:0]  slot_choice;
    logic [9:0]  kicks_used;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic [31:0]           dividend;
    logic [MOD_W-1:0]      divisor;
  } mod_req_t;
endpackage

### rtl/cuckoo_hash_insert_three_way_top.sv
// Three-way cuckoo insert block: one result per input transfer. An insert makes placement
// attempts, each reading a slice, hashing its upper word through the 32-step modulo unit,
// reading the slot and swapping the entry in; it makes up to max_kicks attempts (one when
// max_kicks is zero). No item is taken while one is in progress or while its result waits
// for transfer. A clearing pass after reset empties all 2048 slots of the slot table before
// the first item is accepted; configuration writes are taken throughout.
module cuckoo_hash_insert_three_way_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  chi_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output chi_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import chi_pkg::*;
  `include "cuckoo_hash_insert_three_way_top_assert.svh"

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SLICE = 4'd2;
  localparam logic [3:0] S_MODGO = 4'd3;
  localparam logic [3:0] S_MODW  = 4'd4;
  localparam logic [3:0] S_SLOTR = 4'd5;
  localparam logic [3:0] S_SWAP  = 4'd6;
  localparam logic [3:0] S_READ1 = 4'd7;
  localparam logic [3:0] S_READ2 = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [63:0] slice_mem [3*MAX_ITEMS];
  logic [31:0] key_mem   [TABLE_SLOTS];
  logic [10:0] val_mem   [TABLE_SLOTS];
  logic [1:0]  chc_mem   [TABLE_SLOTS];

  logic [3:0]        state_r;
  logic [MOD_W-1:0]  tsize_r;
  logic [KICK_W-1:0] kmax_r;
  logic [SLOT_W-1:0] clr_r;
  logic [10:0]       v_r;
  logic [1:0]        choice_r;
  logic [KICK_W-1:0] kick_r;
  logic [KICK_W-1:0] limit_r;
  logic [MOD_W-1:0]  mod_r;
  logic [SLOT_W-1:0] slot_r;
  logic [31:0]       key_r;
  logic [63:0]       slice_q;
  logic [31:0]       key_q;
  logic [10:0]       val_q;
  logic [1:0]        chc_q;
  logic              out_valid_r;
  out_item_t         out_r;
  in_item_t          in_r;

  mod_req_t          mreq;
  logic              mdone;
  logic [MOD_W-1:0]  mrem;

  logic              in_fire;
  logic [ITEM_W-1:0] it_idx;
  logic [SLICE_AW-1:0] slice_addr;
  logic              tbl_we;
  logic [SLOT_W-1:0] tbl_waddr;
  logic [SLOT_W-1:0] tbl_raddr;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign it_idx     = v_r[ITEM_W-1:0] - ITEM_W'(1);
  assign slice_addr = SLICE_AW'({2'b00, it_idx} * 3) + SLICE_AW'(choice_r - 2'd1);

  assign mreq.start    = (state_r == S_MODGO);
  assign mreq.dividend = slice_q[63:32];
  assign mreq.divisor  = mod_r;

  chi_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mreq),
    .done      (mdone),
    .remainder (mrem)
  );

  // slot table port use: clearing, then the swap write of each attempt
  assign tbl_we    = (state_r == S_CLEAR) || (state_r == S_SWAP);
  assign tbl_waddr = (state_r == S_CLEAR) ? clr_r : slot_r;
  assign tbl_raddr = (state_r == S_READ1) ? in_r.slot_number : mrem[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (in_fire && in_data.cmd == CMD_LOAD && in_data.slice_sel != 2'd3)
      slice_mem[SLICE_AW'({2'b00, in_data.item_number} * 3) + SLICE_AW'(in_data.slice_sel)]
        <= in_data.slice_data;
    slice_q <= slice_mem[slice_addr];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      key_mem[tbl_waddr] <= key_r;
      val_mem[tbl_waddr] <= v_r;
      chc_mem[tbl_waddr] <= (state_r == S_CLEAR) ? 2'd0 : choice_r;
    end
    key_q <= key_mem[tbl_raddr];
    val_q <= val_mem[tbl_raddr];
    chc_q <= chc_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      tsize_r     <= TABLE_SIZE_RST;
      kmax_r      <= MAX_KICKS_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TABLE_SIZE) tsize_r <= cfg_data[MOD_W-1:0];
        else kmax_r <= cfg_data[KICK_W-1:0];
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + SLOT_W'(1);
          if (clr_r == SLOT_W'(TABLE_SLOTS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            in_r   <= in_data;
            out_r  <= '0;
            v_r    <= {1'b0, in_data.item_number} + 11'd1;
            choice_r <= 2'd1;
            kick_r <= '0;
            limit_r <= (kmax_r == '0) ? KICK_W'(1) : kmax_r;
            if (tsize_r == '0) mod_r <= MOD_W'(1);
            else if (tsize_r > MOD_W'(TABLE_SLOTS)) mod_r <= MOD_W'(TABLE_SLOTS);
            else mod_r <= tsize_r;
            unique case (in_data.cmd)
              CMD_INSERT: state_r <= S_SLICE;
              CMD_READ:   state_r <= S_READ1;
              default:    state_r <= S_OUT;
            endcase
          end
        end
        S_SLICE: state_r <= S_MODGO;
        S_MODGO: begin
          key_r   <= slice_q[31:0];
          state_r <= S_MODW;
        end
        S_MODW: if (mdone) state_r <= S_SLOTR;
        S_SLOTR: begin
          slot_r  <= mrem[SLOT_W-1:0];
          state_r <= S_SWAP;
        end
        S_SWAP: begin
          // entry written this cycle; carry the occupant on
          kick_r <= kick_r + KICK_W'(1);
          if (chc_q == 2'd0) begin
            out_r.kicks_used <= kick_r + KICK_W'(1);
            state_r <= S_OUT;
          end else begin
            v_r      <= val_q;
            choice_r <= (chc_q == 2'd3) ? 2'd1 : chc_q + 2'd1;
            if (kick_r + KICK_W'(1) == limit_r) begin
              out_r.status     <= 1'b1;
              out_r.kicks_used <= limit_r;
              state_r <= S_OUT;
            end else begin
              state_r <= S_SLICE;
            end
          end
        end
        S_READ1: state_r <= S_READ2;
        S_READ2: begin
          if (chc_q != 2'd0) begin
            out_r.slot_choice <= chc_q;
            out_r.slot_key    <= key_q;
            out_r.slot_value  <= val_q;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `CHI_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_ready)
  `CHI_ASSERT_NEXT(a_out_after_fin, clk, rst_n, state_r == S_OUT, out_valid)
  `CHI_ASSERT_IMPL(a_kicks_bound, clk, rst_n, state_r == S_SWAP, kick_r < limit_r)
endmodule

### rtl/chi_mod_unit.sv
// Iterative modulo unit: one quotient bit per cycle; done is raised when the remainder is ready.
// Depends on chi_pkg.
module chi_mod_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  chi_pkg::mod_req_t             req,
  output logic                          done,
  output logic [chi_pkg::MOD_W-1:0]     remainder
);
  import chi_pkg::*;

  logic [31:0]      dvd_r, dvd_nxt;
  logic [MOD_W:0]   rem_r, rem_nxt;
  logic [MOD_W-1:0] dvs_r, dvs_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [MOD_W:0]   shifted;

  assign shifted = {rem_r[MOD_W-1:0], dvd_r[31]};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[30:0], 1'b0};
      // restoring step: subtract when the partial remainder reaches the divisor
      if (shifted >= {1'b0, dvs_r}) rem_nxt = shifted - {1'b0, dvs_r};
      else rem_nxt = shifted;
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[MOD_W-1:0];
endmodule

### bench/cuckoo_hash_insert_three_way_top_test.sv
// Self-checking bench for the three-way cuckoo insert block: directed table, then random
// load/insert/read traffic over several table sizes and kick limits. Depends on chi_pkg.
module cuckoo_hash_insert_three_way_top_test;
  import chi_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = CFG_TABLE_SIZE;
  logic [15:0] cfg_data = '0;

  cuckoo_hash_insert_three_way_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("simulation failed");
    $finish;
  end

  // shadow copy of the table
  logic [63:0] sh_slices [3*MAX_ITEMS];
  logic [31:0] sh_keys   [TABLE_SLOTS];
  logic [10:0] sh_values [TABLE_SLOTS];
  logic [1:0]  sh_choices[TABLE_SLOTS];
  logic [2:0]  loaded    [MAX_ITEMS];
  logic [MOD_W-1:0]  sh_tsize = TABLE_SIZE_RST;
  logic [KICK_W-1:0] sh_kicks = MAX_KICKS_RST;

  out_item_t expected_q[$];
  int mismatches = 0;
  int n_items = 0, n_inserts = 0, n_failed = 0, n_results = 0;
  int burst_left = 0;
  bit vld_hi = 0;

  initial begin
    foreach (sh_choices[i]) sh_choices[i] = 2'd0;
    foreach (loaded[i]) loaded[i] = 3'b000;
  end

  function automatic out_item_t hash_predict(in_item_t x);
    out_item_t r;
    int unsigned md, lim, v, ch, j, it, h, ov, oc;
    logic [63:0] s;
    bit placed;
    r = '0;
    placed = 0;
    case (x.cmd)
      CMD_LOAD: if (x.slice_sel != 2'd3) begin
        sh_slices[x.item_number*3 + x.slice_sel] = x.slice_data;
        loaded[x.item_number][x.slice_sel] = 1'b1;
      end
      CMD_INSERT: begin
        md = (sh_tsize == 0) ? 1 : (sh_tsize > TABLE_SLOTS ? TABLE_SLOTS : sh_tsize);
        lim = (sh_kicks == 0) ? 1 : sh_kicks;
        v = x.item_number + 1;
        ch = 1;
        for (j = 0; j < lim; j++) begin
          it = (v - 1) % MAX_ITEMS;
          s = sh_slices[it*3 + ch - 1];
          h = s[63:32] % md;
          ov = sh_values[h];
          oc = sh_choices[h];
          sh_values[h] = 11'(v);
          sh_keys[h] = s[31:0];
          sh_choices[h] = 2'(ch);
          if (oc == 0) begin
            placed = 1;
            break;
          end
          v = ov;
          ch = oc % 3 + 1;
        end
        r.status = !placed;
        r.kicks_used = placed ? 10'(j + 1) : 10'(lim);
        n_inserts++;
        if (!placed) n_failed++;
      end
      CMD_READ: if (sh_choices[x.slot_number] != 0) begin
        r.slot_choice = sh_choices[x.slot_number];
        r.slot_key = sh_keys[x.slot_number];
        r.slot_value = sh_values[x.slot_number];
      end
      default: ;
    endcase
    return r;
  endfunction

  // receiver stalls: a randomly redrawn mode keeps out_ready high, mostly high or mostly low
  int stall_mode = 0, stall_cnt = 0;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        if (out_data.status !== expected_q[0].status ||
            out_data.slot_key !== expected_q[0].slot_key ||
            out_data.slot_value !== expected_q[0].slot_value ||
            out_data.slot_choice !== expected_q[0].slot_choice ||
            out_data.kicks_used !== expected_q[0].kicks_used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", expected_q[0], out_data);
        end
        expected_q.delete(0);
      end
    end
  end

  task automatic send_item(in_item_t x, bit typed, out_item_t want);
    out_item_t p;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        if (vld_hi) in_valid <= 1'b0;
        vld_hi = 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= x;
    vld_hi = 1;
    do @(posedge clk); while (!in_ready);
    p = hash_predict(x);
    expected_q.insert(expected_q.size(), typed ? want : p);
    n_items++;
  endtask

  // hold the sender until every result is back
  task automatic drain();
    if (vld_hi) in_valid <= 1'b0;
    vld_hi = 0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_TABLE_SIZE) sh_tsize = val[MOD_W-1:0];
    else sh_kicks = val[KICK_W-1:0];
    @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [1:0] c, logic [9:0] it, logic [1:0] sel,
                                  logic [63:0] d, logic [10:0] sl);
    in_item_t x;
    x.cmd = c; x.item_number = it; x.slice_sel = sel; x.slice_data = d; x.slot_number = sl;
    return x;
  endfunction

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } row_t;

  row_t rows[$];

  task automatic add_row(in_item_t x, bit typed);
    row_t r;
    r.item = x; r.typed = typed; r.want = '0;
    rows.insert(rows.size(), r);
  endtask

  task automatic random_item(int unsigned ntry);
    in_item_t x;
    int unsigned it, k, pick, top;
    logic [63:0] d;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // well-formed: load all three slices, then insert
      it = $urandom_range(0, MAX_ITEMS - 1);
      for (k = 0; k < 3; k++) begin
        d = {$urandom, $urandom};
        if ($urandom_range(0, 2) == 0) d[63:32] = $urandom_range(0, 15);
        send_item(mk(CMD_LOAD, 10'(it), 2'(k), d, 11'($urandom)), 0, '0);
      end
      send_item(mk(CMD_INSERT, 10'(it), 2'($urandom), {$urandom, $urandom},
                   11'($urandom)), 0, '0);
    end else if (pick < 55) begin
      send_item(mk(CMD_LOAD, 10'($urandom), 2'($urandom), {$urandom, $urandom},
                   11'($urandom)), 0, '0);
    end else if (pick < 70) begin
      // insert an item whose slices are all present, if one is found
      for (k = 0; k < ntry; k++) begin
        it = $urandom_range(0, MAX_ITEMS - 1);
        if (loaded[it] == 3'b111) break;
      end
      if (loaded[it] == 3'b111)
        send_item(mk(CMD_INSERT, 10'(it), 2'($urandom), {$urandom, $urandom},
                     11'($urandom)), 0, '0);
    end else if (pick < 95) begin
      x = mk(CMD_READ, 10'($urandom), 2'($urandom), {$urandom, $urandom}, 11'($urandom));
      if ($urandom_range(0, 3) != 0 && sh_tsize != 0) begin
        top = (sh_tsize > TABLE_SLOTS) ? TABLE_SLOTS : sh_tsize;
        x.slot_number = 11'($urandom_range(0, top - 1));
      end
      send_item(x, 0, '0);
    end else begin
      send_item(mk(2'd3, 10'($urandom), 2'($urandom), {$urandom, $urandom},
                   11'($urandom)), 0, '0);
    end
  endtask

  int unsigned tsizes[6] = '{2048, 1, 0, 4095, 7, 300};
  int unsigned klims[6]  = '{20, 1, 0, 12, 3, 16};

  initial begin
    int p, i;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    add_row(mk(CMD_READ, 0, 0, 0, 0), 1);
    add_row(mk(CMD_READ, 10'h3FF, 2'd3, '1, 11'h7FF), 1);
    add_row(mk(2'd3, 10'h3FF, 2'd3, '1, 11'h7FF), 1);
    add_row(mk(CMD_LOAD, 0, 2'd3, '1, 0), 1);
    add_row(mk(CMD_LOAD, 0, 0, 64'h0000_0000_FFFF_FFFF, 0), 1);
    add_row(mk(CMD_LOAD, 0, 1, 64'hFFFF_FFFF_0000_0000, 0), 1);
    add_row(mk(CMD_LOAD, 0, 2, '1, 0), 1);
    add_row(mk(CMD_INSERT, 0, 0, 0, 0), 0);
    add_row(mk(CMD_LOAD, 10'h3FF, 0, 64'h0000_0000_1234_5678, 11'h7FF), 1);
    add_row(mk(CMD_LOAD, 10'h3FF, 1, 64'h0000_0533_0000_0001, 11'h7FF), 1);
    add_row(mk(CMD_LOAD, 10'h3FF, 2, 64'hFFFF_FFFF_FFFF_FFFE, 11'h7FF), 1);
    add_row(mk(CMD_INSERT, 10'h3FF, 0, 0, 0), 0);
    add_row(mk(CMD_READ, 0, 0, 0, 0), 0);
    add_row(mk(CMD_LOAD, 5, 0, 64'h0000_0000_AAAA_5555, 0), 1);
    add_row(mk(CMD_LOAD, 5, 1, 64'h0000_0001_5555_AAAA, 0), 1);
    add_row(mk(CMD_LOAD, 5, 2, 64'h0000_0002_0F0F_0F0F, 0), 1);
    add_row(mk(CMD_INSERT, 5, 0, 0, 0), 0);
    add_row(mk(CMD_INSERT, 5, 0, 0, 0), 0);
    add_row(mk(CMD_READ, 0, 0, 0, 0), 0);
    add_row(mk(CMD_READ, 0, 0, 0, 1), 0);
    add_row(mk(CMD_READ, 0, 0, 0, 2), 0);
    add_row(mk(CMD_READ, 0, 0, 0, 11'h7FF), 0);
    foreach (rows[r]) send_item(rows[r].item, rows[r].typed, rows[r].want);

    // random phases over a set of table sizes and kick limits, extremes included
    for (p = 0; p < 6; p++) begin
      write_reg(CFG_TABLE_SIZE, 16'(tsizes[p]));
      write_reg(CFG_MAX_KICKS, 16'(klims[p]));
      for (i = 0; i < 105; i++) random_item(20);
    end
    // longest kick limit (1023), six random items at the full table size
    write_reg(CFG_TABLE_SIZE, 16'd2048);
    write_reg(CFG_MAX_KICKS, 16'hFFFF);
    for (i = 0; i < 6; i++) random_item(20);
    write_reg(CFG_MAX_KICKS, 16'd1);
    write_reg(CFG_TABLE_SIZE, 16'd1331);
    for (i = 0; i < 60; i++) random_item(20);

    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d items, %0d inserts (%0d hit the kick limit), %0d results checked",
             n_items, n_inserts, n_failed, n_results);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_q.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### files.f
+incdir+rtl
rtl/chi_pkg.sv
rtl/chi_mod_unit.sv
rtl/cuckoo_hash_insert_three_way_top.sv
bench/cuckoo_hash_insert_three_way_top_test.sv
